@@ rtl/tbf_pkg.sv @@
// shared constants and word types for the tlv frame bucket finder
package tbf_pkg;

  localparam int unsigned MaxFrameBytesDefault = 65536;
  localparam int unsigned CfgIdxW              = 8;
  localparam logic [31:0] TargetTypeReset      = 32'h0000_0000;
  localparam logic [31:0] TerminatorTypeReset  = 32'h0000_8001;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetType     = 8'd0,
    CfgTerminatorType = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] data_offset;
    logic [15:0] data_length;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_word_t;

  typedef struct packed {
    logic [31:0] search_type;
    logic [31:0] terminator_type;
  } tbf_cfg_t;

endpackage

@@ rtl/tbf_stream_if.sv @@
// valid/ready channel carrying one word of a given payload type
interface tbf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tbf_cfg_regs.sv @@
// configuration register file for target and terminator type codes
module tbf_cfg_regs import tbf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tbf_stream_if.sink   cfg_i,
  output tbf_cfg_t     cfg_o
);

  tbf_cfg_t cfg_q, cfg_d;
  cfg_idx_e idx;

  assign cfg_i.ready = 1'b1;
  assign idx         = cfg_idx_e'(cfg_i.payload.index);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (idx)
        CfgTargetType:     cfg_d.search_type     = cfg_i.payload.data;
        CfgTerminatorType: cfg_d.terminator_type = cfg_i.payload.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.search_type     <= TargetTypeReset;
      cfg_q.terminator_type <= TerminatorTypeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/tbf_parser.sv @@
// per-byte frame parser state and end-of-frame result logic
module tbf_parser import tbf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      consume_i,
  input  in_word_t  word_i,
  input  tbf_cfg_t  cfg_i,
  output out_word_t result_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

  typedef enum logic [2:0] {
    PhName = 3'd0,
    PhStep = 3'd1,
    PhType = 3'd2,
    PhLen  = 3'd3,
    PhSkip = 3'd4,
    PhDone = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     type_q, type_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     skip_q, skip_d;
  logic            match_q, match_d;
  logic [PosW-1:0] moff_q, moff_d;
  logic [31:0]     mlen_q, mlen_d;
  logic            parse_en;
  logic            ok;
  logic [7:0]      b;

  assign b = word_i.data_byte;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    type_d   = type_q;
    len_d    = len_q;
    skip_d   = skip_q;
    match_d  = match_q;
    moff_d   = moff_q;
    mlen_d   = mlen_q;
    pos_d    = (pos_q <= PosMax) ? pos_q + PosW'(1) : pos_q;
    parse_en = (pos_d <= PosMax);
    if (parse_en) begin
      unique case (phase_q)
        PhName: begin
          if (b == 8'd0) begin
            phase_d = PhStep;
            cnt_d   = 2'd0;
          end
        end
        PhStep: begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            phase_d = PhType;
            type_d  = 32'd0;
          end
        end
        PhType: begin
          type_d = {type_q[23:0], b};
          cnt_d  = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            phase_d = PhLen;
            len_d   = 32'd0;
          end
        end
        PhLen: begin
          len_d = {len_q[23:0], b};
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (type_q == cfg_i.terminator_type) begin
              phase_d = PhDone;
            end else if (type_q == cfg_i.search_type) begin
              match_d = 1'b1;
              moff_d  = pos_q + PosW'(1);
              mlen_d  = len_d;
              phase_d = PhDone;
            end else if (len_d == 32'd0) begin
              phase_d = PhType;
              type_d  = 32'd0;
            end else begin
              skip_d  = len_d;
              phase_d = PhSkip;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = PhType;
            type_d  = 32'd0;
          end
        end
        PhDone: phase_d = PhDone;
        default: phase_d = phase_q;
      endcase
    end
  end

  assign ok = match_d && (pos_d <= PosMax) && (moff_d <= pos_d) &&
              ((33'(pos_d) - 33'(moff_d)) >= 33'(mlen_d)) &&
              (32'(moff_d) <= 32'h0000_FFFF) && (mlen_d <= 32'h0000_FFFF);

  always_comb begin
    result_o.found       = ok;
    result_o.data_offset = ok ? 16'(moff_d) : 16'd0;
    result_o.data_length = ok ? mlen_d[15:0] : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhName;
      cnt_q   <= 2'd0;
      pos_q   <= '0;
      type_q  <= 32'd0;
      len_q   <= 32'd0;
      skip_q  <= 32'd0;
      match_q <= 1'b0;
      moff_q  <= '0;
      mlen_q  <= 32'd0;
    end else if (consume_i) begin
      if (word_i.frame_last) begin
        phase_q <= PhName;
        cnt_q   <= 2'd0;
        pos_q   <= '0;
        type_q  <= 32'd0;
        len_q   <= 32'd0;
        skip_q  <= 32'd0;
        match_q <= 1'b0;
        moff_q  <= '0;
        mlen_q  <= 32'd0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        pos_q   <= pos_d;
        type_q  <= type_d;
        len_q   <= len_d;
        skip_q  <= skip_d;
        match_q <= match_d;
        moff_q  <= moff_d;
        mlen_q  <= mlen_d;
      end
    end
  end

  a_match_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> (phase_q == PhDone))
    else $error("match recorded outside done phase");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkip) |-> (skip_q != 32'd0))
    else $error("skip phase with nothing left to skip");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax + PosW'(1))
    else $error("frame position beyond saturation point");

endmodule

@@ rtl/tlv_frame_bucket_finder_core.sv @@
// top level of the tlv frame bucket finder
//
// Searches a byte-serial frame (NUL-terminated name, 4-byte step field,
// then big-endian 32-bit type/length headers with their data) for the
// first bucket whose type equals the target type register.
// in_i   : one frame byte per word, frame_last set on the final byte
// out_o  : one word per frame, sent for the final byte only; found with
//          offset and length of the bucket data, or zeros when not found
// cfg_i  : register writes, index 0 target type, index 1 terminator type;
//          always ready, intended to be written between frames
// Throughput: one byte per cycle while no final byte waits on a pending
// result; every byte is registered in the input register and then
// consumed by the parser, and a frame's result is registered in the
// output register when the parser consumes the frame's final byte.
// Reset clears the parser to the start of a frame, empties both
// registers and restores the type registers to 0 and 0x8001.
// When out_o stalls with a result pending, ordinary bytes keep flowing;
// only the next final byte waits in the input register, and in_i.ready
// drops until the pending result is taken.
module tlv_frame_bucket_finder_core import tbf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tbf_stream_if.sink   in_i,
  tbf_stream_if.source out_o,
  tbf_stream_if.sink   cfg_i
);

  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      advance;
  out_word_t result;
  tbf_cfg_t  cfg;

  tbf_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tbf_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (advance),
    .word_i    (in_word_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign advance = in_valid_q &&
                   (!in_word_q.frame_last || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance && in_word_q.frame_last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_word_q <= in_i.payload;
    end
    if (advance && in_word_q.frame_last) begin
      out_word_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_word_q.frame_last && out_valid_q && !out_o.ready)
      |-> !in_i.ready)
    else $error("final byte taken while a result is still pending");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_word_q.frame_last) |=> out_valid_q)
    else $error("final byte consumed without a result word");

  a_empty_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_word_q.found)
      |-> (out_word_q.data_offset == 16'd0 && out_word_q.data_length == 16'd0))
    else $error("not-found result carries nonzero offset or length");

endmodule
